/* rtl/core/grid_parity_independent_set_tracker_unit_defines.svh */
// Assertion macros used by the checker file of the tracker.
`ifndef GRID_PARITY_INDEPENDENT_SET_TRACKER_UNIT_DEFINES_SVH
`define GRID_PARITY_INDEPENDENT_SET_TRACKER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPIST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPIST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold at a later cycle than the antecedent.
`define GPIST_ASSERT_LATER(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

/* rtl/core/gpist_pkg.sv */
package gpist_pkg;

  // Fixed field widths
  localparam int COL_W     = 6;
  localparam int ROW_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int SIZE_W    = 11;

  // Register reset value for both dimension registers
  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

  // Action codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

endpackage

/* rtl/core/gpist_ram.sv */
module gpist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/grid_parity_independent_set_tracker_unit.sv */
// Each transaction is a read-modify-write of the cell count and row memories: read
// in the accept cycle, written back when the update state finishes, where the result
// is also registered. in_stall stays high until then, so no new transaction is taken.
// Reset: a clearing pass over all MAX_ROWS*MAX_COLUMNS cell addresses (4096 by default) zeroes
// both memories while in_stall is high; column and row limits return to 64.
module grid_parity_independent_set_tracker_unit
  import gpist_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int COUNT_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [COL_W-1:0]     cell_column,
  input  logic [ROW_W-1:0]     cell_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 even_rows_chosen,
  output logic [SIZE_W-1:0]    solution_size,
  output logic                 row_uses_even_columns,
  output logic                 error
);

  localparam int CELL_DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int CAW        = $clog2(CELL_DEPTH);
  localparam int RAW        = $clog2(MAX_ROWS);
  localparam int OCC_BITS   = $clog2((MAX_COLUMNS + 1) / 2 + 1);
  localparam int SUM_BITS   = $clog2(((MAX_ROWS + 1) / 2) * ((MAX_COLUMNS + 1) / 2) + 1);

  typedef struct packed {
    logic                mark;
    logic [OCC_BITS-1:0] even_occ;
    logic [OCC_BITS-1:0] odd_occ;
  } row_entry_t;

  localparam int ROW_ENT_W = $bits(row_entry_t);

  state_t state, state_next;

  logic [CFG_W-1:0] columns_in_use;
  logic [CFG_W-1:0] rows_in_use;

  logic [CAW-1:0] clr_addr;
  logic           clearing;
  logic           clr_done;

  // Captured transaction
  logic           item_remove;
  logic           item_col_odd;
  logic           item_row_odd;
  logic           item_ok;
  logic           item_row_ok;
  logic [CAW-1:0] item_cell_addr;
  logic [RAW-1:0] item_row_addr;

  // Running sums
  logic [SUM_BITS-1:0] even_sum;
  logic [SUM_BITS-1:0] odd_sum;
  logic                even_chosen;

  // Memory ports
  logic                  cell_we;
  logic [CAW-1:0]        cell_waddr;
  logic [COUNT_BITS-1:0] cell_wdata;
  logic [COUNT_BITS-1:0] cell_rdata;
  logic                  row_we;
  logic [RAW-1:0]        row_waddr;
  row_entry_t            row_wdata;
  row_entry_t            row_rdata;
  logic                  rd_en;

  // Input decode
  logic           in_accept;
  logic           in_row_ok;
  logic           in_col_ok;
  logic [31:0]    in_cell_lin;
  logic [CAW-1:0] in_cell_addr;
  logic [RAW-1:0] in_row_addr;

  // Update datapath
  logic                  finish;
  logic                  cnt_zero;
  logic                  cnt_one;
  logic                  cnt_full;
  logic                  upd_err;
  logic                  filled;
  logic                  emptied;
  logic [COUNT_BITS-1:0] cnt_new;
  row_entry_t            row_new;
  logic                  sum_inc;
  logic                  sum_dec;
  logic [SUM_BITS-1:0]   sum_cur;
  logic [SUM_BITS-1:0]   sum_new;
  logic [SUM_BITS-1:0]   even_sum_next;
  logic [SUM_BITS-1:0]   odd_sum_next;
  logic                  even_chosen_next;
  logic [SUM_BITS+SIZE_W-1:0] size_ext;

  // Decode the incoming transaction
  assign in_accept    = in_valid && !in_stall;
  assign in_row_ok    = ({1'b0, cell_row} < rows_in_use) && (32'(cell_row) < 32'(MAX_ROWS));
  assign in_col_ok    = ({1'b0, cell_column} < columns_in_use)
                        && (32'(cell_column) < 32'(MAX_COLUMNS));
  assign in_cell_lin  = 32'(cell_row) * 32'(MAX_COLUMNS) + 32'(cell_column);
  assign in_cell_addr = CAW'(in_cell_lin);
  assign in_row_addr  = RAW'(32'(cell_row));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= DIM_RESET;
      rows_in_use    <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLUMNS: columns_in_use <= cfg_data;
        REG_ROWS:    rows_in_use    <= cfg_data;
        default:     ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer controls
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    clearing   = 1'b0;
    finish     = 1'b0;
    rd_en      = 1'b0;
    case (state)
      ST_CLEAR: begin
        clearing = 1'b1;
        if (clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        finish = !out_valid || !out_stall;
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance the clearing pass over both memories
  assign clr_done = (clr_addr == CAW'(CELL_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (clearing && !clr_done) begin
      clr_addr <= clr_addr + CAW'(1);
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_remove    <= (action == ACT_REMOVE);
      item_col_odd   <= cell_column[0];
      item_row_odd   <= cell_row[0];
      item_ok        <= in_row_ok && in_col_ok;
      item_row_ok    <= in_row_ok;
      item_cell_addr <= in_cell_addr;
      item_row_addr  <= in_row_addr;
    end
  end

  // Cell count update
  assign cnt_zero = (cell_rdata == '0);
  assign cnt_one  = (cell_rdata == COUNT_BITS'(1));
  assign cnt_full = (cell_rdata == '1);
  assign upd_err  = !item_ok || (item_remove ? cnt_zero : cnt_full);
  assign cnt_new  = item_remove ? cell_rdata - COUNT_BITS'(1) : cell_rdata + COUNT_BITS'(1);
  assign filled   = item_ok && !item_remove && cnt_zero;
  assign emptied  = item_ok && item_remove && cnt_one;

  // Row occupancy, mark and sum step
  always_comb begin
    row_new = row_rdata;
    sum_inc = 1'b0;
    sum_dec = 1'b0;
    if (filled && !item_col_odd) begin
      row_new.even_occ = row_rdata.even_occ + OCC_BITS'(1);
      if (!row_rdata.mark) begin
        if (row_new.even_occ > row_rdata.odd_occ) begin
          row_new.mark = 1'b1;
          sum_inc      = 1'b1;
        end
      end else begin
        sum_inc = 1'b1;
      end
    end else if (filled && item_col_odd) begin
      row_new.odd_occ = row_rdata.odd_occ + OCC_BITS'(1);
      if (row_rdata.mark) begin
        if (row_rdata.even_occ < row_new.odd_occ) begin
          row_new.mark = 1'b0;
          sum_inc      = 1'b1;
        end
      end else begin
        sum_inc = 1'b1;
      end
    end else if (emptied && !item_col_odd) begin
      row_new.even_occ = row_rdata.even_occ - OCC_BITS'(1);
      if (row_rdata.mark) begin
        if (row_new.even_occ < row_rdata.odd_occ) begin
          row_new.mark = 1'b0;
        end else begin
          sum_dec = 1'b1;
        end
      end
    end else if (emptied && item_col_odd) begin
      row_new.odd_occ = row_rdata.odd_occ - OCC_BITS'(1);
      if (!row_rdata.mark) begin
        if (row_rdata.even_occ > row_new.odd_occ) begin
          row_new.mark = 1'b1;
        end else begin
          sum_dec = 1'b1;
        end
      end
    end
  end

  // Apply the step to the sum of the row's parity
  assign sum_cur       = item_row_odd ? odd_sum : even_sum;
  assign sum_new       = sum_cur + SUM_BITS'(sum_inc) - SUM_BITS'(sum_dec);
  assign even_sum_next = item_row_odd ? even_sum : sum_new;
  assign odd_sum_next  = item_row_odd ? sum_new : odd_sum;
  assign even_chosen_next = (even_sum_next > odd_sum_next);
  assign size_ext      = (SUM_BITS+SIZE_W)'(even_chosen_next ? even_sum_next : odd_sum_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      even_sum    <= '0;
      odd_sum     <= '0;
      even_chosen <= 1'b0;
    end else if (finish) begin
      even_sum    <= even_sum_next;
      odd_sum     <= odd_sum_next;
      even_chosen <= even_chosen_next;
    end
  end

  // Memory write-back, or zero fill during the clearing pass
  assign cell_we    = clearing || (finish && !upd_err);
  assign cell_waddr = clearing ? clr_addr : item_cell_addr;
  assign cell_wdata = clearing ? '0 : cnt_new;
  assign row_we     = (clearing && (clr_addr < CAW'(MAX_ROWS))) || (finish && (filled || emptied));
  assign row_waddr  = clearing ? clr_addr[RAW-1:0] : item_row_addr;
  assign row_wdata  = clearing ? '0 : row_new;

  gpist_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (rd_en),
    .raddr (in_cell_addr),
    .rdata (cell_rdata)
  );

  gpist_ram #(
    .WIDTH (ROW_ENT_W),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (rd_en),
    .raddr (in_row_addr),
    .rdata (row_rdata)
  );

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      even_rows_chosen      <= even_chosen_next;
      solution_size         <= size_ext[SIZE_W-1:0];
      row_uses_even_columns <= item_row_ok && row_new.mark;
      error                 <= upd_err;
    end
  end

endmodule

/* rtl/core/gpist_checker.sv */
`include "grid_parity_independent_set_tracker_unit_defines.svh"

module gpist_checker
  import gpist_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_write,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 action,
  input logic [COL_W-1:0]     cell_column,
  input logic [ROW_W-1:0]     cell_row,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 even_rows_chosen,
  input logic [SIZE_W-1:0]    solution_size,
  input logic                 row_uses_even_columns,
  input logic                 error
);

  // Hold a stalled result
  `GPIST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(solution_size) && $stable(even_rows_chosen) && $stable(error), "stalled result changed")

  // Stall the input while a transaction is in its update state
  `GPIST_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "input taken during update")

  // Present a result once a transaction has been accepted
  `GPIST_ASSERT_LATER(a_result_latency, clk, rst, in_valid && !in_stall, out_valid, "result missing after accept")

  // Even rows win only with a nonzero sum
  `GPIST_ASSERT_SAME(a_even_nonzero, clk, rst, out_valid && even_rows_chosen, solution_size != '0, "even rows chosen with zero size")

endmodule

bind grid_parity_independent_set_tracker_unit gpist_checker u_gpist_checker (.*);
